### src/rfv_pkg.sv
package rfv_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int NW = 32;
  localparam int FRACSH = 30;
  localparam int T1W = NW + 1;
  localparam int PAW = T1W + WORD_WIDTH;
  localparam int T2W = WORD_WIDTH + 3;
  localparam int T3W = NW + T2W + 1;
  localparam int DOTW = 2 * NW + 2;
  localparam int DW = 35;
  localparam int DSQW = 2 * DW;
  localparam int RW = DSQW + 1;
  localparam int OUTW = 48;
  localparam int QW = OUTW;
  localparam int SATSH = QW - FRACSH;
  localparam int CMPW = (T3W > DSQW + SATSH) ? T3W : DSQW + SATSH;

  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [NW-1:0] q30_t;
  typedef logic signed [OUTW-1:0] field_t;

  typedef struct packed {
    word_t dir_x;
    word_t dir_y;
    word_t dir_z;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
    word_t acc_x;
    word_t acc_y;
    word_t acc_z;
  } rfv_sample_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] shf;
    logic [2:0]         neg;
    logic [2:0]         sat;
    logic [DSQW-1:0]    den;
    logic               dbad;
  } rfv_div_t;

  function automatic q30_t to_q30(word_t v);
    logic [WORD_WIDTH+NW-1:0] e;
    e = {v, {NW{1'b0}}};
    return e[WORD_WIDTH+NW-1 -: NW];
  endfunction

endpackage

### src/rfv_in_if.sv
interface rfv_in_if import rfv_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t dir_x;
  word_t dir_y;
  word_t dir_z;
  word_t vel_x;
  word_t vel_y;
  word_t vel_z;
  word_t acc_x;
  word_t acc_y;
  word_t acc_z;

  modport source (output valid, dir_x, dir_y, dir_z, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, vel_x, vel_y, vel_z,
                acc_x, acc_y, acc_z, output ready);
endinterface

### src/rfv_out_if.sv
interface rfv_out_if import rfv_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t field_x;
  field_t field_y;
  field_t field_z;
  logic   overflow;

  modport source (output valid, field_x, field_y, field_z, overflow, input ready);
  modport sink (input valid, field_x, field_y, field_z, overflow, output ready);
endinterface

### src/rfv_front.sv
module rfv_front import rfv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  rfv_sample_t in_data,
  output logic        out_valid,
  output rfv_div_t    out_data
);

  logic va, vb, vc, vd, ve, vf;

  q30_t  n_a [3];
  q30_t  b_a [3];
  word_t a_a [3];

  q30_t                  n_b  [3];
  logic signed [2*NW-1:0] nb_b [3];
  logic signed [PAW-1:0]  pj_b [3];
  logic signed [PAW-1:0]  pk_b [3];

  q30_t                  n_c [3];
  logic signed [T2W-1:0] t2_c [3];
  logic [DW-1:0]         d_c;
  logic                  dbad_c;

  logic signed [T3W-1:0] m1_d [3];
  logic signed [T3W-1:0] m2_d [3];
  logic [DSQW-1:0]       den_d;
  logic                  dbad_d;

  logic [T3W-1:0]  mag_e [3];
  logic [2:0]      neg_e;
  logic [DSQW-1:0] den_e;
  logic            dbad_e;

  logic signed [T1W-1:0]   t1 [3];
  logic signed [DOTW:0]    d60;
  logic signed [PAW:0]     diff [3];
  logic signed [T3W-1:0]   t3 [3];
  rfv_div_t                f_next;

  localparam logic signed [DOTW:0] ONE60 = (DOTW + 1)'(1) << (2 * FRACSH);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1[i] = T1W'(n_a[i]) - T1W'(b_a[i]);
      diff[i] = (PAW + 1)'(pj_b[i]) - (PAW + 1)'(pk_b[i]);
      t3[i] = m1_d[i] - m2_d[i];
    end
    d60 = ONE60 - ((DOTW + 1)'(nb_b[0]) + (DOTW + 1)'(nb_b[1]) + (DOTW + 1)'(nb_b[2]));
    for (int i = 0; i < 3; i++) begin
      f_next.rem[i] = RW'(mag_e[i] >> SATSH);
      f_next.shf[i] = {mag_e[i][SATSH-1:0], {FRACSH{1'b0}}};
      f_next.sat[i] = CMPW'(mag_e[i]) >= (CMPW'(den_e) << SATSH);
    end
    f_next.neg = neg_e;
    f_next.den = den_e;
    f_next.dbad = dbad_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_a[0] <= to_q30(in_data.dir_x);
      n_a[1] <= to_q30(in_data.dir_y);
      n_a[2] <= to_q30(in_data.dir_z);
      b_a[0] <= to_q30(in_data.vel_x);
      b_a[1] <= to_q30(in_data.vel_y);
      b_a[2] <= to_q30(in_data.vel_z);
      a_a[0] <= in_data.acc_x;
      a_a[1] <= in_data.acc_y;
      a_a[2] <= in_data.acc_z;
      for (int i = 0; i < 3; i++) begin
        n_b[i]  <= n_a[i];
        nb_b[i] <= (2 * NW)'(n_a[i]) * (2 * NW)'(b_a[i]);
        pj_b[i] <= PAW'(t1[NEXT1[i]]) * PAW'(a_a[NEXT2[i]]);
        pk_b[i] <= PAW'(t1[NEXT2[i]]) * PAW'(a_a[NEXT1[i]]);
        n_c[i]  <= n_b[i];
        t2_c[i] <= diff[i][FRACSH +: T2W];
      end
      d_c    <= d60[FRACSH +: DW];
      dbad_c <= d60[DOTW] || (d60[DOTW-1:FRACSH] == '0);
      for (int i = 0; i < 3; i++) begin
        m1_d[i] <= T3W'(n_c[NEXT1[i]]) * T3W'(t2_c[NEXT2[i]]);
        m2_d[i] <= T3W'(n_c[NEXT2[i]]) * T3W'(t2_c[NEXT1[i]]);
      end
      den_d  <= DSQW'(d_c) * DSQW'(d_c);
      dbad_d <= dbad_c;
      for (int i = 0; i < 3; i++) begin
        neg_e[i] <= t3[i][T3W-1];
        mag_e[i] <= t3[i][T3W-1] ? T3W'(-t3[i]) : T3W'(t3[i]);
      end
      den_e    <= den_d;
      dbad_e   <= dbad_d;
      out_data <= f_next;
    end
  end

  assign out_valid = vf;

endmodule

### src/rfv_divider.sv
module rfv_divider import rfv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     in_valid,
  input  rfv_div_t in_data,
  output logic     out_valid,
  output rfv_div_t out_data
);

  rfv_div_t   st [QW];
  logic [QW-1:0] vld;

  function automatic rfv_div_t div_step(rfv_div_t x);
    rfv_div_t        y;
    logic [RW-1:0]   t;
    y = x;
    for (int l = 0; l < 3; l++) begin
      t = {x.rem[l][RW-2:0], x.shf[l][QW-1]};
      if (t >= RW'(x.den)) begin
        y.rem[l] = t - RW'(x.den);
        y.shf[l] = {x.shf[l][QW-2:0], 1'b1};
      end else begin
        y.rem[l] = t;
        y.shf[l] = {x.shf[l][QW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= div_step(in_data);
      for (int s = 1; s < QW; s++) begin
        st[s] <= div_step(st[s-1]);
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_data  = st[QW-1];

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dbad |->
      (out_data.sat[0] || out_data.rem[0] < RW'(out_data.den)) &&
      (out_data.sat[1] || out_data.rem[1] < RW'(out_data.den)) &&
      (out_data.sat[2] || out_data.rem[2] < RW'(out_data.den)))
    else $error("division remainder not below divisor");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("division pipeline moved while stalled");
`endif

endmodule

### src/radiation_field_vector_core.sv
// Far-field radiation vector n x ((n - beta) x a) / (1 - n.beta)^2.
// The sample channel carries direction n and velocity beta in signed Q2.30
// and the velocity derivative a in signed Q16.16. The result channel carries
// the three field components in signed Q32.16 and an overflow flag.
// Overflow is set when a component saturates or when the denominator is not
// positive; in the latter case all three components are zero.
// One request is accepted per cycle while ready is high. A result passes
// through six arithmetic stages, a 48-stage restoring divider that produces
// one quotient bit per stage, and the output register.
// Results leave in request order, one per request.
// When the receiver stalls, the whole pipeline holds, ready drops, and no
// data is lost or repeated. Ready stays high while the output register is
// empty or being taken.
// Reset clears all valid bits; the data registers are not reset.
module radiation_field_vector_core import rfv_pkg::*; (
  input logic       clk,
  input logic       rst,
  rfv_in_if.sink    sample,
  rfv_out_if.source result
);

  logic        adv;
  rfv_sample_t smp;
  logic        f_valid;
  rfv_div_t    f_data;
  logic        d_valid;
  rfv_div_t    d_data;
  logic        out_valid;
  field_t      fld_next [3];
  logic        ovf_next;
  field_t      fld [3];
  logic        ovf;

  assign adv = !out_valid || result.ready;
  assign sample.ready = adv;

  assign smp = '{dir_x: sample.dir_x, dir_y: sample.dir_y, dir_z: sample.dir_z,
                 vel_x: sample.vel_x, vel_y: sample.vel_y, vel_z: sample.vel_z,
                 acc_x: sample.acc_x, acc_y: sample.acc_y, acc_z: sample.acc_z};

  rfv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .in_data   (smp),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  rfv_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_data  (d_data)
  );

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    ovf_next = d_data.dbad;
    for (int l = 0; l < 3; l++) begin
      lim = d_data.neg[l] ? NEG_LIM : POS_LIM;
      mag = d_data.shf[l];
      if (d_data.sat[l] || mag > lim) begin
        mag = lim;
        ovf_next = 1'b1;
      end
      if (d_data.dbad) begin
        fld_next[l] = '0;
      end else begin
        fld_next[l] = d_data.neg[l] ? field_t'(-mag) : field_t'(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fld <= fld_next;
      ovf <= ovf_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.field_x  = fld[0];
  assign result.field_y  = fld[1];
  assign result.field_z  = fld[2];
  assign result.overflow = ovf;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

### bench/tb_rfv_if.sv
`timescale 1ns / 100ps
// Interfaces come from the RTL source; this file holds the expected result type for the bench.
package tb_rfv_types;
  import rfv_pkg::*;
  typedef struct {
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
    logic               ovf;
  } field_exp_t;
endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rfv_pkg::*;
  import tb_rfv_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  rfv_in_if  sample ();
  rfv_out_if result ();

  radiation_field_vector_core dut (.clk(clk), .rst(rst), .sample(sample), .result(result));

  rfv_sample_t pending_q[$];
  field_exp_t  field_q[$];
  int errors = 0;
  int quiet = 0;
  bit loading = 1'b1;
  bit calm = 1'b0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic logic signed [127:0] cross_div(logic signed [127:0] t3,
                                                    logic [127:0] den, output bit sat);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    neg = t3 < 0;
    mag = neg ? -t3 : t3;
    q = (mag << 30) / den;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    sat = 1'b0;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic field_exp_t radiation_field(rfv_sample_t s);
    logic signed [127:0] n[3], b[3], a[3], t1[3], t2[3], t3, dot, d60, d, r;
    logic [127:0] den;
    field_exp_t e;
    bit sat, flag;
    int j, k;
    n[0] = s.dir_x; n[1] = s.dir_y; n[2] = s.dir_z;
    b[0] = s.vel_x; b[1] = s.vel_y; b[2] = s.vel_z;
    a[0] = s.acc_x; a[1] = s.acc_y; a[2] = s.acc_z;
    dot = n[0] * b[0] + n[1] * b[1] + n[2] * b[2];
    d60 = (128'sd1 <<< 60) - dot;
    d = d60 >>> 30;
    e.fx = 0; e.fy = 0; e.fz = 0; e.ovf = 1'b1;
    if (d <= 0) return e;
    for (int i = 0; i < 3; i++) t1[i] = n[i] - b[i];
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3; k = (i + 2) % 3;
      t2[i] = (t1[j] * a[k] - t1[k] * a[j]) >>> 30;
    end
    den = d * d;
    flag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3; k = (i + 2) % 3;
      t3 = n[j] * t2[k] - n[k] * t2[j];
      r = cross_div(t3, den, sat);
      flag |= sat;
      if (i == 0) e.fx = r[47:0];
      else if (i == 1) e.fy = r[47:0];
      else e.fz = r[47:0];
    end
    e.ovf = flag;
    return e;
  endfunction

  function automatic word_t pick_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h4000_0000)) - (mode * 0);
      2: return -$signed($urandom_range(0, 32'h4000_0000));
      3: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic rfv_sample_t rand_sample();
    rfv_sample_t s;
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) begin
      // Physically sensible: small-ish direction and velocity, moderate derivative.
      s.dir_x = pick_word($urandom_range(1, 2)) >>> $urandom_range(0, 2);
      s.dir_y = pick_word($urandom_range(1, 2)) >>> $urandom_range(0, 2);
      s.dir_z = pick_word($urandom_range(1, 2)) >>> $urandom_range(0, 2);
      s.vel_x = pick_word($urandom_range(1, 2)) >>> $urandom_range(0, 3);
      s.vel_y = pick_word($urandom_range(1, 2)) >>> $urandom_range(0, 3);
      s.vel_z = pick_word($urandom_range(1, 2)) >>> $urandom_range(0, 3);
      s.acc_x = pick_word($urandom_range(0, 3));
      s.acc_y = pick_word($urandom_range(0, 3));
      s.acc_z = pick_word($urandom_range(0, 3));
    end else begin
      s.dir_x = pick_word($urandom_range(0, 4)); s.dir_y = pick_word($urandom_range(0, 4));
      s.dir_z = pick_word($urandom_range(0, 4)); s.vel_x = pick_word($urandom_range(0, 4));
      s.vel_y = pick_word($urandom_range(0, 4)); s.vel_z = pick_word($urandom_range(0, 4));
      s.acc_x = pick_word($urandom_range(0, 4)); s.acc_y = pick_word($urandom_range(0, 4));
      s.acc_z = pick_word($urandom_range(0, 4));
    end
    return s;
  endfunction

  function automatic rfv_sample_t make_sample(word_t nx, word_t ny, word_t nz, word_t bx,
                                              word_t by, word_t bz, word_t ax, word_t ay,
                                              word_t az);
    rfv_sample_t s;
    s.dir_x = nx; s.dir_y = ny; s.dir_z = nz;
    s.vel_x = bx; s.vel_y = by; s.vel_z = bz;
    s.acc_x = ax; s.acc_y = ay; s.acc_z = az;
    return s;
  endfunction

  localparam word_t ONE = 32'sh4000_0000;
  localparam word_t MAXW = 32'sh7fff_ffff;
  localparam word_t MINW = 32'sh8000_0000;

  initial begin
    pending_q.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_sample(ONE, 0, 0, 0, 0, 0, 0, 32'sh10000, 0));
    pending_q.push_back(make_sample(0, ONE, 0, 32'sh2000_0000, 0, 0, 0, 0, 32'sh10000));
    pending_q.push_back(make_sample(ONE, 0, 0, ONE, 0, 0, 0, 32'sh10000, 0));
    pending_q.push_back(make_sample(ONE, 0, 0, 32'sh3fff_ffff, 0, 0, MAXW, MAXW, MAXW));
    pending_q.push_back(make_sample(ONE, 0, 0, 32'sh3fff_0000, 0, 0, 0, MAXW, MINW));
    pending_q.push_back(make_sample(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW));
    pending_q.push_back(make_sample(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW));
    pending_q.push_back(make_sample(MAXW, MINW, MAXW, MINW, MAXW, MINW, MAXW, MINW, MAXW));
    pending_q.push_back(make_sample(MINW, 0, 0, MAXW, 0, 0, MAXW, MINW, MAXW));
    pending_q.push_back(make_sample(-ONE, 0, 0, ONE, 0, 0, 0, MINW, MAXW));
    pending_q.push_back(make_sample(0, 0, MAXW, 0, 0, MINW, MINW, MAXW, 1));
    pending_q.push_back(make_sample(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_q.push_back(make_sample(1, 1, 1, 1, 1, 1, 1, 1, 1));
    for (int i = 0; i < 1840; i++) pending_q.push_back(rand_sample());
    loading = 1'b0;
  end

  initial begin
    sample.valid = 1'b0;
    {sample.dir_x, sample.dir_y, sample.dir_z} = '0;
    {sample.vel_x, sample.vel_y, sample.vel_z} = '0;
    {sample.acc_x, sample.acc_y, sample.acc_z} = '0;
    result.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (pending_q.size() < 300) calm <= !loading;
      if (in_taken) begin
        // The request was taken at the last rising edge.
        void'(pending_q.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        sample.valid <= 1'b0;
      end else if (!calm && (!sample.valid || in_taken) && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(1, 14) - 1;
        sample.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        rfv_sample_t s;
        s = pending_q[0];
        sample.valid <= 1'b1;
        sample.dir_x <= s.dir_x; sample.dir_y <= s.dir_y; sample.dir_z <= s.dir_z;
        sample.vel_x <= s.vel_x; sample.vel_y <= s.vel_y; sample.vel_z <= s.vel_z;
        sample.acc_x <= s.acc_x; sample.acc_y <= s.acc_y; sample.acc_z <= s.acc_z;
      end else begin
        sample.valid <= 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 14) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= sample.valid && sample.ready;
    if (!rst) begin
      if ((sample.valid && sample.ready) || (result.valid && result.ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (sample.valid && sample.ready) begin
        rfv_sample_t s;
        s.dir_x = sample.dir_x; s.dir_y = sample.dir_y; s.dir_z = sample.dir_z;
        s.vel_x = sample.vel_x; s.vel_y = sample.vel_y; s.vel_z = sample.vel_z;
        s.acc_x = sample.acc_x; s.acc_y = sample.acc_y; s.acc_z = sample.acc_z;
        field_q.push_back(radiation_field(s));
      end
      if (result.valid && result.ready) begin
        field_exp_t e;
        if (field_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h ovf=%b", $time, result.field_x,
                   result.field_y, result.field_z, result.overflow);
          errors++;
        end else begin
          e = field_q.pop_front();
          if (result.field_x !== e.fx) begin
            $display("%0t: field_x expected %h actual %h", $time, e.fx, result.field_x);
            errors++;
          end
          if (result.field_y !== e.fy) begin
            $display("%0t: field_y expected %h actual %h", $time, e.fy, result.field_y);
            errors++;
          end
          if (result.field_z !== e.fz) begin
            $display("%0t: field_z expected %h actual %h", $time, e.fz, result.field_z);
            errors++;
          end
          if (result.overflow !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e.ovf, result.overflow);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    while (loading || pending_q.size() > 0 || field_q.size() > 0) begin
      @(posedge clk);
      if (quiet > 2000) begin
        $display("radiation_field_vector_core regression: fail");
        $finish;
      end
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && field_q.size() == 0) begin
      $display("radiation_field_vector_core regression: pass");
    end else begin
      $display("radiation_field_vector_core regression: fail");
    end
    $finish;
  end
endmodule
